// File: src/nmea_sentence_field_extractor_top_defines.svh
// Assertion macros for the NMEA field extractor.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef NMEA_SENTENCE_FIELD_EXTRACTOR_TOP_DEFINES_SVH
`define NMEA_SENTENCE_FIELD_EXTRACTOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define NSFE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define NSFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NSFE_ASSERT(label, prop, msg)
`define NSFE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: src/nsfe_pkg.sv
// Shared types and constants for the NMEA field extractor.
// No dependencies; used by the controller, datapath and top level.
package nsfe_pkg;

    localparam int LINE_LIMIT_DEFAULT = 128;
    localparam int FIELD_MAX_DEFAULT  = 19;

    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;

    localparam int HEADER_LEN = 6;
    localparam logic [3:0] FIELD_SEL_MAX = 4'd13;
    localparam logic [3:0] DELIM_MAX     = 4'd15;

    localparam logic [3:0]  FIELD_SELECT_RESET   = 4'd0;
    localparam logic [5:0]  IDLE_LIMIT_RESET     = 6'd56;
    localparam logic [47:0] HEADER_PATTERN_RESET = 48'h244750524D43;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_SELECT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_PATTERN = 2'd2;

    typedef enum logic [1:0] {
        KIND_CHAR    = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_TIMEOUT = 2'd2
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic rd;
        logic put;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit_single;
        logic emit_field;
        logic slot_free;
        logic burst_last;
    } stat_t;

endpackage

// File: src/nsfe_ctrl.sv
// Controller state machine for the NMEA field extractor.
// Depends on nsfe_pkg and the assertion macro header.
`include "nmea_sentence_field_extractor_top_defines.svh"

module nsfe_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  nsfe_pkg::stat_t stat,
    output nsfe_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_PUT  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.take   = 1'b0;
        cmd.rd     = 1'b0;
        cmd.put    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (stat.emit_field)
                    begin
                        state_next = S_READ;
                    end
                    else if (stat.emit_single)
                    begin
                        state_next = S_PUT;
                    end
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_PUT;
            end
            S_PUT:
            begin
                if (stat.slot_free)
                begin
                    cmd.put    = 1'b1;
                    state_next = stat.burst_last ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `NSFE_ASSERT(a_state_onehot, $onehot(state_reg), "state register is not one-hot")
    `NSFE_ASSERT_NEXT(a_read_then_put, state_reg == S_READ, state_reg == S_PUT,
        "field store read not followed by a put")
    `NSFE_ASSERT_NEXT(a_field_starts_read, cmd.take && stat.emit_field, state_reg == S_READ,
        "field burst did not start with a read")
    `NSFE_ASSERT(a_put_needs_slot, cmd.put |-> stat.slot_free,
        "result loaded while the output slot was busy")

endmodule

// File: src/nsfe_dp.sv
// Datapath for the NMEA field extractor: config, line state, field store, output.
// Depends on nsfe_pkg; driven by nsfe_ctrl commands.
module nsfe_dp #(
    parameter int LINE_LIMIT = nsfe_pkg::LINE_LIMIT_DEFAULT,
    parameter int FIELD_MAX  = nsfe_pkg::FIELD_MAX_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [nsfe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nsfe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              func,
    input  logic [7:0]                        data_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        kind,
    output logic [7:0]                        field_char,
    output logic                              last,
    input  nsfe_pkg::cmd_t                    cmd,
    output nsfe_pkg::stat_t                   stat
);

    localparam int POS_W  = $clog2(LINE_LIMIT + 1);
    localparam int FLEN_W = $clog2(FIELD_MAX + 1);
    localparam int ADDR_W = (FIELD_MAX > 1) ? $clog2(FIELD_MAX) : 1;

    logic [3:0]  field_select_reg;
    logic [5:0]  idle_limit_reg;
    logic [47:0] header_reg;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              match_reg, match_next;
    logic [3:0]        dcount_reg, dcount_next;
    logic [FLEN_W-1:0] flen_reg, flen_next;
    logic [5:0]        idle_reg, idle_next;

    logic [7:0]        store [FIELD_MAX];
    logic [7:0]        rd_data_reg;
    logic [FLEN_W-1:0] burst_len_reg;
    logic [FLEN_W-1:0] burst_idx_reg;
    nsfe_pkg::kind_t   pend_kind_reg;

    logic              out_valid_reg;
    nsfe_pkg::kind_t   out_kind_reg;
    logic [7:0]        out_char_reg;
    logic              out_last_reg;

    logic       is_end, is_delim, in_line, in_header;
    logic [6:0] idle_inc;
    logic       timeout, line_ok, closed, field_hit, has_chars, store_we;
    logic [7:0] hdr_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_select_reg <= nsfe_pkg::FIELD_SELECT_RESET;
            idle_limit_reg   <= nsfe_pkg::IDLE_LIMIT_RESET;
            header_reg       <= nsfe_pkg::HEADER_PATTERN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nsfe_pkg::CFG_FIELD_SELECT:   field_select_reg <= cfg_wdata[3:0];
                nsfe_pkg::CFG_IDLE_LIMIT:     idle_limit_reg   <= cfg_wdata[5:0];
                nsfe_pkg::CFG_HEADER_PATTERN: header_reg       <= cfg_wdata[47:0];
                default:
                begin
                end
            endcase
        end
    end

    // Expected header character for the current position, first one in the top byte.
    always_comb
    begin
        case (pos_reg[2:0])
            3'd0:    hdr_byte = header_reg[47:40];
            3'd1:    hdr_byte = header_reg[39:32];
            3'd2:    hdr_byte = header_reg[31:24];
            3'd3:    hdr_byte = header_reg[23:16];
            3'd4:    hdr_byte = header_reg[15:8];
            3'd5:    hdr_byte = header_reg[7:0];
            default: hdr_byte = 8'd0;
        endcase
    end

    assign is_end    = (data_byte == nsfe_pkg::CHAR_CR) || (data_byte == nsfe_pkg::CHAR_LF);
    assign is_delim  = (data_byte == nsfe_pkg::CHAR_COMMA) || (data_byte == nsfe_pkg::CHAR_STAR);
    assign in_line   = (pos_reg < POS_W'(LINE_LIMIT));
    assign in_header = (pos_reg < POS_W'(nsfe_pkg::HEADER_LEN));
    assign idle_inc  = {1'b0, idle_reg} + 7'd1;
    assign timeout   = (idle_inc >= {1'b0, idle_limit_reg});
    assign line_ok   = match_reg && !in_header;
    assign closed    = (field_select_reg <= nsfe_pkg::FIELD_SEL_MAX) &&
                       ({1'b0, dcount_reg} >= ({1'b0, field_select_reg} + 5'd2));
    assign field_hit = (field_select_reg <= nsfe_pkg::FIELD_SEL_MAX) &&
                       ({1'b0, dcount_reg} == ({1'b0, field_select_reg} + 5'd1));
    assign has_chars = (flen_reg != '0);
    assign store_we  = cmd.take && !func && !is_end && in_line && !is_delim && field_hit &&
                       (flen_reg < FLEN_W'(FIELD_MAX));

    assign stat.emit_field  = !func && is_end && line_ok && closed && has_chars;
    assign stat.emit_single = func ? timeout : (is_end && line_ok && !(closed && has_chars));
    assign stat.slot_free   = !out_valid_reg || out_ready;
    assign stat.burst_last  = (pend_kind_reg != nsfe_pkg::KIND_CHAR) ||
                              ((burst_idx_reg + FLEN_W'(1)) == burst_len_reg);

    always_comb
    begin
        pos_next    = pos_reg;
        match_next  = match_reg;
        dcount_next = dcount_reg;
        flen_next   = flen_reg;
        idle_next   = idle_reg;
        if (cmd.take)
        begin
            if (func)
            begin
                if (timeout)
                begin
                    idle_next   = 6'd1;
                    pos_next    = '0;
                    match_next  = 1'b1;
                    dcount_next = 4'd0;
                    flen_next   = '0;
                end
                else
                begin
                    idle_next = idle_inc[5:0];
                end
            end
            else if (is_end)
            begin
                if (line_ok)
                begin
                    idle_next = 6'd1;
                end
                pos_next    = '0;
                match_next  = 1'b1;
                dcount_next = 4'd0;
                flen_next   = '0;
            end
            else if (in_line)
            begin
                if (in_header && (data_byte != hdr_byte))
                begin
                    match_next = 1'b0;
                end
                if (is_delim)
                begin
                    if (dcount_reg != nsfe_pkg::DELIM_MAX)
                    begin
                        dcount_next = dcount_reg + 4'd1;
                    end
                end
                else if (store_we)
                begin
                    flen_next = flen_reg + FLEN_W'(1);
                end
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            match_reg  <= 1'b1;
            dcount_reg <= 4'd0;
            flen_reg   <= '0;
            idle_reg   <= 6'd1;
        end
        else
        begin
            pos_reg    <= pos_next;
            match_reg  <= match_next;
            dcount_reg <= dcount_next;
            flen_reg   <= flen_next;
            idle_reg   <= idle_next;
        end
    end

    // Field store: one write port at the fill position, one registered read port.
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store[flen_reg[ADDR_W-1:0]] <= data_byte;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= store[burst_idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_kind_reg <= nsfe_pkg::KIND_EMPTY;
            burst_len_reg <= '0;
            burst_idx_reg <= '0;
        end
        else if (cmd.take)
        begin
            if (func)
            begin
                pend_kind_reg <= nsfe_pkg::KIND_TIMEOUT;
            end
            else if (stat.emit_field)
            begin
                pend_kind_reg <= nsfe_pkg::KIND_CHAR;
            end
            else
            begin
                pend_kind_reg <= nsfe_pkg::KIND_EMPTY;
            end
            burst_len_reg <= flen_reg;
            burst_idx_reg <= '0;
        end
        else if (cmd.put)
        begin
            burst_idx_reg <= burst_idx_reg + FLEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.put)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.put)
        begin
            out_kind_reg <= pend_kind_reg;
            out_char_reg <= (pend_kind_reg == nsfe_pkg::KIND_CHAR) ? rd_data_reg : 8'd0;
            out_last_reg <= stat.burst_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = out_kind_reg;
    assign field_char = out_char_reg;
    assign last       = out_last_reg;

endmodule

// File: src/nmea_sentence_field_extractor_top.sv
// Top level of the NMEA sentence field extractor.
// Depends on nsfe_pkg, nsfe_ctrl and nsfe_dp.

// The block takes one request per received byte (func 0) or idle tick (func 1) and
// pulls one field out of each line whose first six characters equal header_pattern.
// The field is the one that follows delimiter number field_select, counting both
// commas and asterisks from zero. When a CR or LF closes a matching line, the field
// characters come out one result each with last set on the final one, or a single
// empty-field result when the field is missing, unclosed or empty; lines that do not
// match give nothing. Fields longer than FIELD_MAX characters are cut, and bytes past
// LINE_LIMIT characters in a line are ignored except for the line end. Idle ticks
// count up from one, and a timeout result is given when the count reaches idle_limit;
// the count restarts after a timeout or a matching line end. A byte or tick that gives
// no result is taken at once and leaves the block ready. A request that gives results
// keeps the input stalled until its final result sits in the output register; every
// character goes through the single registered read port of the field store before
// it is presented. A stalled output holds the block in its put state until the slot
// frees. Configuration is written through cfg_we, cfg_index and cfg_wdata; the user
// must write it only while the block is idle, as the block does not enforce this.
// Indexes past the register list are ignored.
module nmea_sentence_field_extractor_top #(
    parameter int LINE_LIMIT = nsfe_pkg::LINE_LIMIT_DEFAULT,
    parameter int FIELD_MAX  = nsfe_pkg::FIELD_MAX_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [nsfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nsfe_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            func,
    input  logic [7:0]                      data_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      kind,
    output logic [7:0]                      field_char,
    output logic                            last
);

    // Commands flow from the controller into the datapath; status flows back.
    nsfe_pkg::cmd_t  cmd;
    nsfe_pkg::stat_t stat;

    nsfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the configuration, the line state, the field store and the
    // output register that lets a finished result wait for the consumer.
    nsfe_dp #(
        .LINE_LIMIT (LINE_LIMIT),
        .FIELD_MAX  (FIELD_MAX)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .func       (func),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .field_char (field_char),
        .last       (last),
        .cmd        (cmd),
        .stat       (stat)
    );

endmodule
